FILE: rtl/core/oisc_pkg.sv
// Package for the ordered ID set with cursor: field widths, command codes
// and the "no ID" constant. No dependencies.
package oisc_pkg;

    localparam int CMD_W = 4;
    localparam int ID_W  = 64;
    localparam int POS_W = 8;
    localparam int CNT_W = 9;

    // command codes; unused codes behave as a query
    localparam logic [CMD_W-1:0] CMD_QUERY     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SELECT    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLR_SEL   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CLR_CHG   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_GET_AT    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_NEXT      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_PREV      = 4'd8;

    // reported when there is no selection or no value
    localparam logic signed [ID_W-1:0] NONE_ID = '1;

endpackage

FILE: rtl/core/oisc_if.sv
// Channel interfaces for the ordered ID set with cursor: command channel
// and result channel. Depends on oisc_pkg.
interface oisc_in_if
    import oisc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [ID_W-1:0]  item_id;
    logic [POS_W-1:0]        position;

    modport source (output valid, command, item_id, position, input ready);
    modport sink   (input valid, command, item_id, position, output ready);
endinterface

interface oisc_out_if
    import oisc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    success;
    logic                    overflow;
    logic                    id_present;
    logic                    id_is_selected;
    logic signed [ID_W-1:0]  result_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    selection_valid;
    logic signed [ID_W-1:0]  selected_value;
    logic                    changed_flag;

    modport source (output valid, success, overflow, id_present, id_is_selected,
                    result_value, entry_count, selection_valid, selected_value,
                    changed_flag, input ready);
    modport sink   (input valid, success, overflow, id_present, id_is_selected,
                    result_value, entry_count, selection_valid, selected_value,
                    changed_flag, output ready);
endinterface

FILE: rtl/core/ordered_id_set_with_cursor_unit.sv
// Ordered ID set with selection cursor: table memory, scan/compaction
// sequencer and result register. Depends on oisc_pkg and oisc_if.
//
//  channel  dir  payload                                       handshake
//  i_in     in   command, item_id, position                    valid/ready
//  o_out    out  success, overflow, id_present, id_is_selected, valid/ready
//                result_value, entry_count, selection_valid,
//                selected_value, changed_flag
//
// Sequence: every command scans the table through the single memory read port,
// one entry per cycle, then executes. A remove that finds its ID adds a
// compaction pass; get at, next and previous add a table read when they have an
// entry to read; then the result register is loaded, and the next command can
// transfer in the cycle after that load. Reset is synchronous; the table holds
// no valid bits. A new command is taken while a result waits; the sequencer
// stalls before loading the result register until it is free.
module ordered_id_set_with_cursor_unit
    import oisc_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    oisc_in_if.sink           i_in,
    oisc_out_if.source        o_out
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EXEC, S_SHIFT, S_READ, S_READW, S_FIN
    } t_state;

    t_state                  r_state;

    // captured command
    logic [CMD_W-1:0]        r_cmd;
    logic signed [ID_W-1:0]  r_id;
    logic [POS_W-1:0]        r_pos;

    // architectural state
    logic [CW-1:0]           r_used;
    logic signed [ID_W-1:0]  r_choice;
    logic                    r_choice_vld;
    logic                    r_changed;

    // sequencer and search results
    logic [CW-1:0]           r_idx;
    logic                    r_pend;
    logic [CW-1:0]           r_pend_idx;
    logic                    r_hit_id;
    logic [CW-1:0]           r_hit_idx;
    logic                    r_hit_ch;
    logic [CW-1:0]           r_ch_idx;

    // per-command outcome
    logic                    r_success;
    logic                    r_overflow;
    logic                    r_present;
    logic signed [ID_W-1:0]  r_value;

    // result register
    logic                    r_out_valid;
    logic                    r_o_success;
    logic                    r_o_overflow;
    logic                    r_o_present;
    logic                    r_o_selected;
    logic signed [ID_W-1:0]  r_o_value;
    logic [CNT_W-1:0]        r_o_count;
    logic                    r_o_sel_vld;
    logic signed [ID_W-1:0]  r_o_sel_value;
    logic                    r_o_changed;

    // table memory
    logic [ID_W-1:0]         r_mem [MAX_ENTRIES];
    logic signed [ID_W-1:0]  r_rdata;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [ID_W-1:0]         mem_wdata;
    logic [AW-1:0]           mem_raddr;

    logic                    in_xfer;
    logic                    add_ok;
    logic                    full;
    logic                    issue;
    logic                    cur_ok;
    logic [CW-1:0]           cur_idx;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign full      = (r_used >= CW'(MAX_ENTRIES));
    assign add_ok    = (r_cmd == CMD_ADD) && !r_hit_id && !full;
    assign issue     = (r_idx < r_used);
    assign mem_raddr = r_idx[AW-1:0];

    // cursor position, valid only when the selection was found in the table
    assign cur_ok  = r_choice_vld && r_hit_ch;
    assign cur_idx = cur_ok ? r_ch_idx : '0;

    // write port: append on add, move down one slot during compaction
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_used[AW-1:0];
        mem_wdata = r_id;
        if (r_state == S_EXEC && add_ok) begin
            mem_we = 1'b1;
        end else if (r_state == S_SHIFT && r_pend) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_pend_idx - CW'(1));
            mem_wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_choice     <= NONE_ID;
            r_choice_vld <= 1'b0;
            r_changed    <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // S_FIN reloads the result register itself on a result transfer
            if (r_out_valid && o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd      <= i_in.command;
                        r_id       <= i_in.item_id;
                        r_pos      <= i_in.position;
                        r_idx      <= '0;
                        r_pend     <= 1'b0;
                        r_hit_id   <= 1'b0;
                        r_hit_ch   <= 1'b0;
                        r_success  <= 1'b0;
                        r_overflow <= 1'b0;
                        r_value    <= NONE_ID;
                        r_state    <= S_SCAN;
                    end
                end

                // search for the input ID and the current selection
                S_SCAN: begin
                    if (r_pend) begin
                        if (!r_hit_id && r_rdata == r_id) begin
                            r_hit_id  <= 1'b1;
                            r_hit_idx <= r_pend_idx;
                        end
                        if (!r_hit_ch && r_rdata == r_choice) begin
                            r_hit_ch <= 1'b1;
                            r_ch_idx <= r_pend_idx;
                        end
                    end
                    if (issue) begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_idx;
                        r_idx      <= r_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_EXEC;
                        end
                    end
                end

                S_EXEC: begin
                    r_present <= r_hit_id;
                    r_state   <= S_FIN;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (!r_hit_id) begin
                                if (full) begin
                                    r_overflow <= 1'b1;
                                end else begin
                                    r_used    <= r_used + CW'(1);
                                    r_success <= 1'b1;
                                    r_present <= 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            r_present <= 1'b0;
                            if (r_hit_id) begin
                                if (r_choice_vld && r_choice == r_id) begin
                                    r_choice     <= NONE_ID;
                                    r_choice_vld <= 1'b0;
                                    r_changed    <= 1'b1;
                                end
                                r_idx   <= r_hit_idx + CW'(1);
                                r_pend  <= 1'b0;
                                r_state <= S_SHIFT;
                            end
                        end
                        CMD_SELECT: begin
                            if (r_hit_id) begin
                                if (!r_choice_vld || r_choice != r_id) begin
                                    r_changed <= 1'b1;
                                end
                                r_choice     <= r_id;
                                r_choice_vld <= 1'b1;
                                r_success    <= 1'b1;
                            end
                        end
                        CMD_CLR_SEL: begin
                            if (r_choice_vld) begin
                                r_choice     <= NONE_ID;
                                r_choice_vld <= 1'b0;
                                r_changed    <= 1'b1;
                            end
                        end
                        CMD_CLR_CHG: begin
                            r_changed <= 1'b0;
                        end
                        CMD_GET_AT: begin
                            if (PW'(r_pos) < PW'(r_used)) begin
                                r_idx   <= CW'(r_pos);
                                r_state <= S_READ;
                            end
                        end
                        CMD_NEXT: begin
                            if (r_used != '0) begin
                                if (cur_ok && (cur_idx + CW'(1) != r_used)) begin
                                    r_idx <= cur_idx + CW'(1);
                                end else begin
                                    r_idx <= '0;
                                end
                                r_state <= S_READ;
                            end
                        end
                        CMD_PREV: begin
                            if (r_used != '0) begin
                                if (cur_idx == '0) begin
                                    r_idx <= r_used - CW'(1);
                                end else begin
                                    r_idx <= cur_idx - CW'(1);
                                end
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // compaction: read slot j+1, write it to slot j next cycle
                S_SHIFT: begin
                    if (issue) begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_idx;
                        r_idx      <= r_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_used    <= r_used - CW'(1);
                            r_success <= 1'b1;
                            r_state   <= S_FIN;
                        end
                    end
                end

                S_READ: begin
                    r_state <= S_READW;
                end

                S_READW: begin
                    r_value <= r_rdata;
                    if (r_cmd != CMD_GET_AT) begin
                        if (!r_choice_vld || r_choice != r_rdata) begin
                            r_changed <= 1'b1;
                        end
                        r_choice     <= r_rdata;
                        r_choice_vld <= 1'b1;
                    end
                    r_state <= S_FIN;
                end

                // load the result once the result register is free
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid   <= 1'b1;
                        r_o_success   <= r_success;
                        r_o_overflow  <= r_overflow;
                        r_o_present   <= r_present;
                        r_o_selected  <= r_choice_vld && (r_choice == r_id);
                        r_o_value     <= r_value;
                        r_o_count     <= CNT_W'(r_used);
                        r_o_sel_vld   <= r_choice_vld;
                        r_o_sel_value <= r_choice_vld ? r_choice : NONE_ID;
                        r_o_changed   <= r_changed;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.success         = r_o_success;
    assign o_out.overflow        = r_o_overflow;
    assign o_out.id_present      = r_o_present;
    assign o_out.id_is_selected  = r_o_selected;
    assign o_out.result_value    = r_o_value;
    assign o_out.entry_count     = r_o_count;
    assign o_out.selection_valid = r_o_sel_vld;
    assign o_out.selected_value  = r_o_sel_value;
    assign o_out.changed_flag    = r_o_changed;

endmodule
